>>> design/adc_pkg.sv
// ----------------------------------------------------------------------------
// adc_pkg - shared constants for the antenna delay calibrator
// Field widths, register reset values and configuration port sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package adc_pkg;

    // Payload field widths
    localparam int MEAS_W   = 16;
    localparam int DELAY_W  = 16;
    localparam int STEP_W   = 16;
    localparam int TARGET_W = 15;
    localparam int TRIAL_W  = 4;

    // Number of search trials averaged into the final delay
    localparam int ADC_TRIALS = 8;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Register reset values
    localparam logic [DELAY_W-1:0]  START_DELAY_RST  = 16'd16384;
    localparam logic [STEP_W-1:0]   INITIAL_STEP_RST = 16'd100;
    localparam logic [STEP_W-1:0]   STOP_STEP_RST    = 16'd3;
    localparam logic [TARGET_W-1:0] TARGET_RST       = 15'd1000;

endpackage

`default_nettype wire

>>> design/adc_if.sv
// ----------------------------------------------------------------------------
// adc_if - valid/ready channels of the antenna delay calibrator
// adc_meas_if carries measured ranges in, adc_result_if carries results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface adc_meas_if import adc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [MEAS_W-1:0] measured_distance_mm;

    modport source (output valid, output measured_distance_mm, input ready);
    modport sink   (input valid, input measured_distance_mm, output ready);
endinterface

interface adc_result_if import adc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DELAY_W-1:0] antenna_delay;
    logic [TRIAL_W-1:0] trial_number;
    logic               done_res;

    modport source (output valid, output antenna_delay, output trial_number,
                    output done_res, input ready);
    modport sink   (input valid, input antenna_delay, input trial_number,
                    input done_res, output ready);
endinterface

`default_nettype wire

>>> design/antenna_delay_calibrator.sv
// ----------------------------------------------------------------------------
// antenna_delay_calibrator - binary search for the radio antenna delay
// Steps the antenna delay towards the value that makes measured ranges match
// a known target distance, and averages the delays found over several trials.
// ----------------------------------------------------------------------------
// Usage:
//   meas   : one measured range (signed mm) per transfer.
//   result : one transfer per accepted range, carrying the delay to program
//            now, the number of completed trials and the done flag.
//   APB    : start_delay (0x0), initial_step (0x4), stop_step (0x8),
//            target_distance_mm (0xC). Write only while the block is idle.
//            Writing start_delay or initial_step before the search has
//            finished restarts the running trial; completed trials are kept.
// Timing:
//   The whole update is one pass of logic between the input handshake and
//   the result register, so a result appears in the cycle after its range
//   is accepted, and a new range can be taken every cycle (one item per
//   cycle) unless a stalled result register holds meas.ready low. The longest
//   path runs from the range through the error subtract and the step select into the delay add.
// Reset: all registers but the result payload return to their reset values, no result is pending.
// Stall: the result register holds its transfer while result.ready is low;
//   meas is still accepted whenever the result register is empty or draining.
// After the last trial every range is ignored and each result repeats the
// average with done_res set, until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module antenna_delay_calibrator import adc_pkg::*; #(
    parameter int TRIALS = ADC_TRIALS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    adc_meas_if.sink                   meas,
    adc_result_if.source               result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // Sum of TRIALS delays, and an exact divide by TRIALS as a multiply by
    // a rounded-up reciprocal: floor(x * ceil(2^S / T) / 2^S) == floor(x / T)
    // for every x below 2^SUM_W when S = SUM_W + clog2(T).
    localparam int SUM_W     = DELAY_W + $clog2(TRIALS);
    localparam int DIV_SHIFT = SUM_W + $clog2(TRIALS);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TRIALS) - 64'd1) / 64'(TRIALS));
    localparam logic [TRIAL_W-1:0] TRIALS_CNT = TRIAL_W'(TRIALS);

    typedef enum logic [1:0] {
        REG_START_DELAY  = 2'd0,
        REG_INITIAL_STEP = 2'd1,
        REG_STOP_STEP    = 2'd2,
        REG_TARGET       = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    // Configuration registers
    logic [DELAY_W-1:0]  start_delay_reg,  start_delay_next;
    logic [STEP_W-1:0]   initial_step_reg, initial_step_next;
    logic [STEP_W-1:0]   stop_step_reg,    stop_step_next;
    logic [TARGET_W-1:0] target_reg,       target_next;

    // Search state
    logic [DELAY_W-1:0]  current_delay_reg, current_delay_next;
    logic [STEP_W-1:0]   step_reg,          step_next;
    sign_t               last_sign_reg,     last_sign_next;
    logic [TRIAL_W-1:0]  trials_reg,        trials_next;
    logic [SUM_W-1:0]    sum_reg,           sum_next;
    logic                finished_reg,      finished_next;

    // Result register
    logic                out_valid_reg,     out_valid_next;
    logic [DELAY_W-1:0]  out_delay_reg,     out_delay_next;
    logic [TRIAL_W-1:0]  out_trial_reg,     out_trial_next;
    logic                out_done_reg,      out_done_next;

    logic                cfg_wr;
    reg_idx_t            reg_idx;
    logic                accept;
    logic signed [MEAS_W:0] err;
    sign_t               sign;
    logic [STEP_W-1:0]   step_upd;
    logic [SUM_W-1:0]    sum_upd;
    logic [TRIAL_W-1:0]  trials_upd;
    logic [PROD_W-1:0]   avg_prod;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    // Take a range whenever the result register is free or being drained
    assign meas.ready = !out_valid_reg || result.ready;
    assign accept     = meas.valid && meas.ready;

    // Register read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_START_DELAY:  prdata = APB_DATA_W'(start_delay_reg);
            REG_INITIAL_STEP: prdata = APB_DATA_W'(initial_step_reg);
            REG_STOP_STEP:    prdata = APB_DATA_W'(stop_step_reg);
            REG_TARGET:       prdata = APB_DATA_W'(target_reg);
            default:          prdata = '0;
        endcase
    end

    // Range error and its sign
    always_comb
    begin
        err = $signed({meas.measured_distance_mm[MEAS_W-1], meas.measured_distance_mm})
            - $signed({2'b00, target_reg});
        if (err[MEAS_W])
            sign = SIGN_NEG;
        else if (err != '0)
            sign = SIGN_POS;
        else
            sign = SIGN_NONE;
    end

    // Halve the step on a change of sign; zero errors never count as a change
    assign step_upd = (sign != SIGN_NONE && last_sign_reg != SIGN_NONE &&
                       sign != last_sign_reg) ? (step_reg >> 1) : step_reg;

    // Trial bookkeeping and the final average
    assign sum_upd    = sum_reg + SUM_W'(current_delay_reg);
    assign trials_upd = trials_reg + TRIAL_W'(1);
    assign avg_prod   = PROD_W'(sum_upd) * PROD_W'(RECIP);

    always_comb
    begin
        start_delay_next   = start_delay_reg;
        initial_step_next  = initial_step_reg;
        stop_step_next     = stop_step_reg;
        target_next        = target_reg;
        current_delay_next = current_delay_reg;
        step_next          = step_reg;
        last_sign_next     = last_sign_reg;
        trials_next        = trials_reg;
        sum_next           = sum_reg;
        finished_next      = finished_reg;

        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_START_DELAY:
                begin
                    start_delay_next = pwdata[DELAY_W-1:0];
                    if (!finished_reg)
                    begin
                        current_delay_next = pwdata[DELAY_W-1:0];
                        step_next          = initial_step_reg;
                        last_sign_next     = SIGN_NONE;
                    end
                end
                REG_INITIAL_STEP:
                begin
                    initial_step_next = pwdata[STEP_W-1:0];
                    if (!finished_reg)
                    begin
                        current_delay_next = start_delay_reg;
                        step_next          = pwdata[STEP_W-1:0];
                        last_sign_next     = SIGN_NONE;
                    end
                end
                REG_STOP_STEP: stop_step_next = pwdata[STEP_W-1:0];
                REG_TARGET:    target_next    = pwdata[TARGET_W-1:0];
                default: ;
            endcase
        end
        else if (accept && !finished_reg)
        begin
            if (step_reg < stop_step_reg)
            begin
                // Close the trial: record the delay, drop this range
                sum_next    = sum_upd;
                trials_next = trials_upd;
                if (trials_upd >= TRIALS_CNT)
                begin
                    finished_next      = 1'b1;
                    current_delay_next = avg_prod[DIV_SHIFT +: DELAY_W];
                end
                else
                begin
                    current_delay_next = start_delay_reg;
                    step_next          = initial_step_reg;
                    last_sign_next     = SIGN_NONE;
                end
            end
            else
            begin
                // Advance the delay; raise on a long range, lower otherwise
                step_next      = step_upd;
                last_sign_next = sign;
                if (sign == SIGN_POS)
                    current_delay_next = current_delay_reg + step_upd;
                else
                    current_delay_next = current_delay_reg - step_upd;
            end
        end
    end

    // Result register: load on accept, drop once the transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_delay_next = out_delay_reg;
        out_trial_next = out_trial_reg;
        out_done_next  = out_done_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_delay_next = current_delay_next;
            out_trial_next = trials_next;
            out_done_next  = finished_next;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg   <= START_DELAY_RST;
            initial_step_reg  <= INITIAL_STEP_RST;
            stop_step_reg     <= STOP_STEP_RST;
            target_reg        <= TARGET_RST;
            current_delay_reg <= START_DELAY_RST;
            step_reg          <= INITIAL_STEP_RST;
            last_sign_reg     <= SIGN_NONE;
            trials_reg        <= '0;
            sum_reg           <= '0;
            finished_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            start_delay_reg   <= start_delay_next;
            initial_step_reg  <= initial_step_next;
            stop_step_reg     <= stop_step_next;
            target_reg        <= target_next;
            current_delay_reg <= current_delay_next;
            step_reg          <= step_next;
            last_sign_reg     <= last_sign_next;
            trials_reg        <= trials_next;
            sum_reg           <= sum_next;
            finished_reg      <= finished_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result payload: no reset needed
    always_ff @(posedge clk)
    begin
        out_delay_reg <= out_delay_next;
        out_trial_reg <= out_trial_next;
        out_done_reg  <= out_done_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.antenna_delay = out_delay_reg;
    assign result.trial_number  = out_trial_reg;
    assign result.done_res      = out_done_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.done_res |-> result.trial_number == TRIALS_CNT)
        else $error("done result without a full trial count");

    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished flag cleared without reset");

    a_trials_bound: assert property (@(posedge clk) disable iff (!rst_n)
        trials_reg <= TRIALS_CNT)
        else $error("trial count beyond the trial total");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        meas.valid && meas.ready |=> result.valid)
        else $error("accepted range produced no result");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the antenna delay calibrator
// Drives measured ranges over the meas channel and register writes over APB,
// predicts every result with a cycle-free model of the delay search, and
// compares each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
    import adc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ROUNDS  = 16;
    localparam int OPEN_ROUND_LEN = 16;

    // Register indexes; byte address is four times the index
    typedef enum int {
        REG_START_DELAY  = 0,
        REG_INITIAL_STEP = 1,
        REG_STOP_STEP    = 2,
        REG_TARGET       = 3
    } cal_reg_e;

    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } err_sign_e;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [TRIAL_W-1:0] trials;
        logic               done;
    } cal_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    adc_meas_if   meas_ch ();
    adc_result_if res_ch ();

    antenna_delay_calibrator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .meas    (meas_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow registers of the configuration port
    logic [DELAY_W-1:0]  cfg_start_delay;
    logic [STEP_W-1:0]   cfg_initial_step;
    logic [STEP_W-1:0]   cfg_stop_step;
    logic [TARGET_W-1:0] cfg_target;

    // Predicted search state
    logic [DELAY_W-1:0]  cal_delay;
    logic [STEP_W-1:0]   cal_step;
    err_sign_e           cal_last_sign;
    logic [TRIAL_W-1:0]  cal_trials;
    int unsigned         cal_sum;
    bit                  cal_finished;

    // Predicted results, oldest first
    cal_result_t expected_results[$];

    // Idling controls: sender gaps, receiver stalls, and the quiet tail
    bit gaps_on;
    bit stalls_on;
    bit quiet_tail;

    int mismatch_count;
    int idle_cycles;

    // ------------------------------------------------------------------------
    // Search predictor
    // ------------------------------------------------------------------------

    // Reload the trial from the start registers; completed trials are kept
    function automatic void restart_search();
        cal_delay     = cfg_start_delay;
        cal_step      = cfg_initial_step;
        cal_last_sign = SIGN_NONE;
    endfunction

    function automatic void reset_calibrator();
        cfg_start_delay  = START_DELAY_RST;
        cfg_initial_step = INITIAL_STEP_RST;
        cfg_stop_step    = STOP_STEP_RST;
        cfg_target       = TARGET_RST;
        restart_search();
        cal_trials   = '0;
        cal_sum      = 0;
        cal_finished = 1'b0;
    endfunction

    // Mirror a register write; start values restart the trial until finished
    function automatic void apply_register(cal_reg_e idx, logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_START_DELAY:
            begin
                cfg_start_delay = value[DELAY_W-1:0];
                if (!cal_finished)
                    restart_search();
            end
            REG_INITIAL_STEP:
            begin
                cfg_initial_step = value[STEP_W-1:0];
                if (!cal_finished)
                    restart_search();
            end
            REG_STOP_STEP:
                cfg_stop_step = value[STEP_W-1:0];
            REG_TARGET:
                cfg_target = value[TARGET_W-1:0];
            default:
                ;
        endcase
    endfunction

    // Advance the search by one measured range and return the result it causes
    function automatic cal_result_t search_step(logic signed [MEAS_W-1:0] range_mm);
        int          err;
        err_sign_e   sgn;
        cal_result_t res;
        if (!cal_finished)
        begin
            if (cal_step < cfg_stop_step)
            begin
                // trial over: this range is dropped, the delay goes into the sum
                cal_sum    = cal_sum + cal_delay;
                cal_trials = cal_trials + 1'b1;
                if (cal_trials >= ADC_TRIALS)
                begin
                    cal_finished = 1'b1;
                    cal_delay    = DELAY_W'(cal_sum / ADC_TRIALS);
                end
                else
                    restart_search();
            end
            else
            begin
                err = int'(range_mm) - int'(cfg_target);
                sgn = (err > 0) ? SIGN_POS : ((err < 0) ? SIGN_NEG : SIGN_NONE);
                // halve only on a true sign reversal; a zero error never counts
                if (sgn != SIGN_NONE && cal_last_sign != SIGN_NONE && sgn != cal_last_sign)
                    cal_step = cal_step >> 1;
                cal_last_sign = sgn;
                if (err > 0)
                    cal_delay = cal_delay + cal_step;
                else
                    cal_delay = cal_delay - cal_step;
            end
        end
        res.delay  = cal_delay;
        res.trials = cal_trials;
        res.done   = cal_finished;
        return res;
    endfunction

    // Range a radio would report: drive the delay towards true_delay, with a
    // share of random-sign errors and of raw noise across all sixteen bits
    function automatic logic signed [MEAS_W-1:0] probe_range(int true_delay);
        int pick;
        int range_mm;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return MEAS_W'($urandom);
        range_mm = cfg_target;
        if (pick < 4)
            range_mm = range_mm + int'($urandom_range(0, 64)) - 32;
        else
            range_mm = range_mm + true_delay - int'(cal_delay)
                       + int'($urandom_range(0, 4)) - 2;
        if (range_mm > 32767)
            range_mm = 32767;
        else if (range_mm < -32768)
            range_mm = -32768;
        return MEAS_W'(range_mm);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, receiver, result check and watchdog
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hold ready low in random bursts while stalls are enabled
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stalls_on && !quiet_tail && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s", $time, what);
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : result_check
        cal_result_t want;
        cal_result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.delay  = res_ch.antenna_delay;
            got.trials = res_ch.trial_number;
            got.done   = res_ch.done_res;
            if (expected_results.size() == 0)
                flag_mismatch($sformatf("unexpected result delay=%0d trials=%0d done=%0b",
                                        got.delay, got.trials, got.done));
            else
            begin
                want = expected_results.pop_front();
                if (got.delay !== want.delay || got.trials !== want.trials
                    || got.done !== want.done)
                    flag_mismatch($sformatf({"result mismatch: expected delay=%0d ",
                                             "trials=%0d done=%0b, got delay=%0d ",
                                             "trials=%0d done=%0b"},
                                            want.delay, want.trials, want.done,
                                            got.delay, got.trials, got.done));
            end
        end
    end

    // Abort when no transfer of any kind has happened for too long
    always @(posedge clk)
    begin
        if ((meas_ch.valid && meas_ch.ready) || (res_ch.valid && res_ch.ready)
            || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------

    // Offer one range, optionally after a gap, and predict on the transfer
    task automatic send_range(input logic signed [MEAS_W-1:0] range_mm);
        int gap;
        if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            meas_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        meas_ch.valid                <= 1'b1;
        meas_ch.measured_distance_mm <= range_mm;
        do
            @(posedge clk);
        while (!meas_ch.ready);
        expected_results.push_back(search_step(range_mm));
    endtask

    // Drop valid and wait until every predicted result has been seen
    task automatic drain_results();
        @(negedge clk);
        meas_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle completing when pready is high
    task automatic write_register(input cal_reg_e idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        apply_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain, then load all four registers; stop and target go first so the
    // restart caused by the start values sees the new settings
    task automatic setup_search(input int stop_step, input int target, input int start_delay,
                                input int initial_step);
        drain_results();
        write_register(REG_STOP_STEP, stop_step);
        write_register(REG_TARGET, target);
        write_register(REG_START_DELAY, start_delay);
        write_register(REG_INITIAL_STEP, initial_step);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: range extremes, a sign reversal, a zero error
    task automatic test_defaults();
        send_range(16'sh7fff);
        send_range(16'sh8000);
        send_range(16'sd1000);
        send_range(16'sd999);
        send_range(16'sd1001);
        send_range(16'sd0);
    endtask

    // Delay wraps above 65535 and below 0; largest initial step
    task automatic test_delay_wrap();
        setup_search(1, 1000, 65535, 1);
        send_range(16'sd2000);
        drain_results();
        write_register(REG_START_DELAY, 0);
        send_range(16'sd0);
        drain_results();
        write_register(REG_INITIAL_STEP, 65535);
        send_range(16'sd5000);
    endtask

    // Target at both ends of its range
    task automatic test_target_extremes();
        drain_results();
        write_register(REG_TARGET, 32767);
        send_range(16'sh7fff);
        send_range(16'sh8000);
        drain_results();
        write_register(REG_TARGET, 0);
        send_range(16'sd0);
        send_range(-16'sd1);
        send_range(16'sd1);
        send_range(16'sh7fff);
    endtask

    // Stop step of zero: the step halves down to zero and the search never ends
    task automatic test_zero_stop_step();
        setup_search(0, 1000, 20000, 3);
        repeat (3)
        begin
            send_range(16'sd2000);
            send_range(16'sd0);
        end
    endtask

    // Trial ends: zero initial step, then the largest stop step
    task automatic test_trial_end();
        setup_search(1, 1000, 30000, 0);
        send_range(16'sd1234);
        setup_search(65535, 1000, 40000, 100);
        send_range(-16'sd77);
    endtask

    // Rounds of realistic searches; a few end a trial, the rest run open with
    // stop step zero so that most items stay inside the search
    task automatic test_random_search();
        int                 true_delay;
        int                 count;
        int                 target;
        int                 start_delay;
        int                 stop_step;
        int                 initial_step;
        bit                 ending;
        logic [TRIAL_W-1:0] trials_before;
        for (int round = 0; round < RANDOM_ROUNDS; round++)
        begin
            ending     = (round % 3 == 2) && (cal_trials < ADC_TRIALS - 1);
            true_delay = $urandom_range(0, 65535);
            case ($urandom_range(0, 5))
                0:       start_delay = 0;
                1:       start_delay = 65535;
                default: start_delay = $urandom_range(0, 65535);
            endcase
            if (ending)
            begin
                target       = $urandom_range(100, 30000);
                stop_step    = $urandom_range(1, 16);
                initial_step = $urandom_range(stop_step, 4096);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       target = 0;
                    1:       target = 32767;
                    default: target = $urandom_range(0, 32767);
                endcase
                stop_step    = 0;
                initial_step = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(1, 2048);
            end
            setup_search(stop_step, target, start_delay, initial_step);
            // leave some rounds free of idling on either side
            gaps_on   = $urandom_range(0, 2) != 0;
            stalls_on = $urandom_range(0, 2) != 0;
            if (ending)
            begin
                trials_before = cal_trials;
                count = 0;
                while (cal_trials == trials_before && count < 200)
                begin
                    send_range(probe_range(true_delay));
                    count++;
                end
            end
            else
                repeat (OPEN_ROUND_LEN) send_range(probe_range(true_delay));
        end
    endtask

    // Run the last trials to completion with no idling, then check that ranges
    // and start register writes no longer move the averaged delay
    task automatic test_finish();
        int true_delay;
        int count;
        quiet_tail = 1'b1;
        true_delay = $urandom_range(0, 65535);
        setup_search(2, $urandom_range(100, 30000), $urandom_range(0, 65535),
                     $urandom_range(2, 1024));
        count = 0;
        while (!cal_finished && count < 400)
        begin
            send_range(probe_range(true_delay));
            count++;
        end
        repeat (4) send_range(MEAS_W'($urandom));
        setup_search(1, 500, 1234, 7);
        repeat (4) send_range(probe_range(true_delay));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n                        = 1'b0;
        meas_ch.valid                = 1'b0;
        meas_ch.measured_distance_mm = '0;
        res_ch.ready                 = 1'b0;
        psel                         = 1'b0;
        penable                      = 1'b0;
        pwrite                       = 1'b0;
        paddr                        = '0;
        pwdata                       = '0;
        gaps_on                      = 1'b0;
        stalls_on                    = 1'b0;
        quiet_tail                   = 1'b0;
        mismatch_count               = 0;
        idle_cycles                  = 0;
        reset_calibrator();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_defaults();
        test_delay_wrap();
        test_target_extremes();
        test_zero_stop_step();
        test_trial_end();
        test_random_search();
        test_finish();

        drain_results();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
design/adc_pkg.sv
design/adc_if.sv
design/antenna_delay_calibrator.sv
dv/testbench.sv
